/* rtl/bgd_pkg.sv */
package bgd_pkg;

  localparam int ROW_W   = 13;
  localparam int COL_W   = 13;
  localparam int DIM_W   = 14;
  localparam int Q_DEPTH = 4;

  localparam logic [7:0] PIX_MAX = 8'd255;

  // register indexes of the configuration port
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [12:0]      h;
  } dims_t;

  typedef struct packed {
    dims_t dims;
    logic  restart;
  } fctl_t;

  // one stream position: column of five raw rows plus row a-2 around it
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [7:0]       v0;
    logic [7:0]       v1;
    logic [7:0]       v2;
    logic [7:0]       v3;
    logic [7:0]       v4;
    logic [7:0]       hm2;
    logic [7:0]       hm1;
    logic [7:0]       hp1;
    logic [7:0]       hp2;
  } item_t;

endpackage

/* rtl/bayer_gradient_demosaic.sv */
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_action, in_raw_pixel
// out_      output     out_valid/out_stall  out_blue, out_green, out_red, out_row_end,
//                                           out_frame_end
// cfg_      input      cfg_we               cfg_index, cfg_data
//
// One transaction per clock in both directions while neither side stalls; a pixel
// leaves after the transaction that releases it, passing the raw-line prefetch,
// the queue and the two back-end stages (green, then color).
// rst_n is synchronous; it restores 640x480 and restarts the frame. Line stores
// need no clearing pass: only rows written in the current frame are read.
// in_stall rises only while the four-entry queue is full; out_stall holds the
// back end in place while out_valid is high, and the front keeps filling the queue.
module bayer_gradient_demosaic #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_raw_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic        out_row_end,
  output logic        out_frame_end
);
  import bgd_pkg::*;

  logic  q_full, q_empty, q_pop, push;
  item_t item, head;
  fctl_t ctl;

  // hold input only when the queue has no room
  assign in_stall = q_full;

  // front: count positions, keep raw lines, classify raw vs flush transactions
  bgd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_acc       (in_valid && !in_stall),
    .in_action    (in_action),
    .in_raw_pixel (in_raw_pixel),
    .push         (push),
    .item         (item),
    .ctl          (ctl)
  );

  // short queue decouples the sensor side from the output side
  bgd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (item),
    .pop   (q_pop),
    .head  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: green line store, green interpolation, color window and output register
  bgd_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .head          (head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_blue      (out_blue),
    .out_green     (out_green),
    .out_red       (out_red),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end)
  );

endmodule

/* rtl/bgd_ram.sv */
module bgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/bgd_front.sv */
module bgd_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [12:0]    cfg_data,
  input  logic           in_acc,
  input  logic           in_action,
  input  logic [7:0]     in_raw_pixel,
  output logic           push,
  output bgd_pkg::item_t item,
  output bgd_pkg::fctl_t ctl
);
  import bgd_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [DIM_W-1:0] W_LIM = DIM_W'(MAX_WIDTH - (MAX_WIDTH % 2));

  logic [11:0]      fw_r;
  logic [12:0]      fh_r;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] w_ext, w_eff, c3;
  logic [12:0]      h_ext, h_eff;
  logic             draining, last;
  logic [7:0]       pix;
  logic [31:0]      e0_r, ep1_r, rdata;
  logic [7:0]       em1_r, em2_r;

  always_comb begin
    w_ext = {2'b00, fw_r[11:1], 1'b0};
    priority if (w_ext < DIM_W'(4)) w_eff = DIM_W'(4);
    else if (w_ext > W_LIM)         w_eff = W_LIM;
    else                            w_eff = w_ext;
    h_ext = {fh_r[12:1], 1'b0};
    priority if (h_ext < 13'd4) h_eff = 13'd4;
    else if (h_ext > 13'd4096)  h_eff = 13'd4096;
    else                        h_eff = h_ext;
  end

  assign ctl.dims.w  = w_eff;
  assign ctl.dims.h  = h_eff;
  assign ctl.restart = cfg_we;

  // raw samples only count inside the frame, flush ticks only past it
  assign draining = row_r >= h_eff;
  assign push     = in_acc && (in_action ? draining : !draining);
  assign last     = (row_r == 13'(h_eff + 13'd3)) && (col_r == '0);
  assign pix      = in_action ? 8'd0 : in_raw_pixel;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (push) begin
      if ({1'b0, col_r} + DIM_W'(1) >= w_eff) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
      if (last) begin
        row_nxt = '0;
        col_nxt = '0;
      end
    end
    if (cfg_we) begin
      row_nxt = '0;
      col_nxt = '0;
    end
  end

  // prefetch the column three ahead, wrapping into the next row
  always_comb begin
    c3 = {1'b0, col_r} + DIM_W'(3);
    if (c3 >= w_eff) c3 = c3 - w_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= 12'd640;
      fh_r  <= 13'd480;
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WIDTH:  fw_r <= cfg_data[11:0];
          CFG_HEIGHT: fh_r <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      em2_r <= em1_r;
      em1_r <= e0_r[23:16];
      e0_r  <= ep1_r;
      ep1_r <= rdata;
    end
  end

  // each column word holds rows a-1 .. a-4, newest in the top byte
  bgd_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_raw (
    .clk   (clk),
    .we    (push),
    .waddr (col_r[AW-1:0]),
    .wdata ({pix, e0_r[31:8]}),
    .re    (push),
    .raddr (c3[AW-1:0]),
    .rdata (rdata)
  );

  assign item.row = row_r;
  assign item.col = col_r;
  assign item.v0  = pix;
  assign item.v1  = e0_r[31:24];
  assign item.v2  = e0_r[23:16];
  assign item.v3  = e0_r[15:8];
  assign item.v4  = e0_r[7:0];
  assign item.hm2 = em2_r;
  assign item.hm1 = em1_r;
  assign item.hp1 = ep1_r[23:16];
  assign item.hp2 = rdata[23:16];

endmodule

/* rtl/bgd_queue.sv */
module bgd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bgd_pkg::item_t din,
  input  logic           pop,
  output bgd_pkg::item_t head,
  output logic           full,
  output logic           empty
);
  import bgd_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  item_t          slot_r [Q_DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [PW:0]    cnt_r;

  assign full  = cnt_r == (PW+1)'(Q_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= din;
  end

endmodule

/* rtl/bgd_back.sv */
module bgd_back #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic           clk,
  input  logic           rst_n,
  input  bgd_pkg::fctl_t ctl,
  input  bgd_pkg::item_t head,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_blue,
  output logic [7:0]     out_green,
  output logic [7:0]     out_red,
  output logic           out_row_end,
  output logic           out_frame_end
);
  import bgd_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  // rows of an entry: index 0 is r-1, 1 is r, 2 is r+1
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [2:0][7:0]   raw;
    logic [2:0][7:0]   g;
  } went_t;

  function automatic logic signed [12:0] sx(input logic [7:0] v);
    return $signed({5'b0, v});
  endfunction

  function automatic logic signed [12:0] absv(input logic signed [12:0] v);
    return v[12] ? -v : v;
  endfunction

  function automatic logic signed [12:0] tdiv(input logic signed [12:0] v,
                                               input logic [1:0] k);
    logic signed [12:0] bias, s;
    bias = v[12] ? 13'((1 << k) - 1) : 13'sd0;
    s    = v + bias;
    return s >>> k;
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [12:0] v);
    if (v[12]) return 8'd0;
    if (v > $signed({5'b0, PIX_MAX})) return PIX_MAX;
    return v[7:0];
  endfunction

  function automatic logic [7:0] diag(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] e, input logic [7:0] f,
                                      input logic [7:0] ga, input logic [7:0] gb,
                                      input logic [7:0] ge, input logic [7:0] gf,
                                      input logic [7:0] gc);
    logic signed [12:0] ln, lp, dn, dp, t;
    ln = 13'(2 * sx(gc)) - sx(ga) - sx(gb);
    lp = 13'(2 * sx(gc)) - sx(ge) - sx(gf);
    dn = absv(sx(a) - sx(b)) + absv(ln);
    dp = absv(sx(e) - sx(f)) + absv(lp);
    priority if (dn < dp) t = ((sx(a) + sx(b)) >>> 1) + tdiv(ln, 2'd1);
    else if (dn > dp)     t = ((sx(e) + sx(f)) >>> 1) + tdiv(lp, 2'd1);
    else t = ((sx(a) + sx(b) + sx(e) + sx(f)) >>> 2) + tdiv(ln + lp, 2'd2);
    return clamp8(t);
  endfunction

  function automatic logic [7:0] guide(input logic [7:0] x0, input logic [7:0] x1,
                                       input logic [7:0] g0, input logic [7:0] g1,
                                       input logic [7:0] gc);
    logic signed [12:0] lap;
    lap = 13'(2 * sx(gc)) - sx(g0) - sx(g1);
    return clamp8(((sx(x0) + sx(x1)) >>> 1) + tdiv(lap, 2'd2));
  endfunction

  logic        adv;
  logic        b1_valid_r, wv_r, out_valid_r;
  item_t       b1_r;
  logic [15:0] gq;
  logic [7:0]  g_new;
  went_t       w0_r, w1_r, w2_r, went_new;
  logic [2:0]  live_r;
  logic        emit;
  logic [7:0]  bl, gn, rd;
  logic [7:0]  blue_r, green_r, red_r;
  logic        row_end_r, frame_end_r;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  // interpolated green of row a-2 at the column of the stage-one item
  always_comb begin
    logic signed [12:0] p, l, rr, u, d, ll, r2, uu, dd, hl, vl, dh, dv, t;
    logic border;
    p  = sx(b1_r.v2);  l  = sx(b1_r.hm1); rr = sx(b1_r.hp1);
    u  = sx(b1_r.v3);  d  = sx(b1_r.v1);
    ll = sx(b1_r.hm2); r2 = sx(b1_r.hp2);
    uu = sx(b1_r.v4);  dd = sx(b1_r.v0);
    hl = 13'(2 * p) - ll - r2;
    vl = 13'(2 * p) - uu - dd;
    dh = absv(l - rr) + absv(hl);
    dv = absv(u - d) + absv(vl);
    priority if (dh < dv) t = ((l + rr) >>> 1) + tdiv(hl, 2'd2);
    else if (dh > dv)     t = ((u + d) >>> 1) + tdiv(vl, 2'd2);
    else t = ((l + rr + u + d) >>> 2) + tdiv(hl + vl, 2'd3);
    border = (b1_r.row < 13'd4) || (b1_r.row >= ctl.dims.h) || (b1_r.col < 13'd2) ||
             ({1'b0, b1_r.col} + DIM_W'(2) >= ctl.dims.w);
    if (border) begin
      // border greens copy from the quad; row parity follows row a
      if (!b1_r.row[0]) g_new = b1_r.col[0] ? b1_r.v2 : b1_r.hp1;
      else              g_new = b1_r.col[0] ? b1_r.hm1 : b1_r.v2;
    end else if (b1_r.row[0] ^ b1_r.col[0]) begin
      g_new = b1_r.v2;
    end else begin
      g_new = clamp8(t);
    end
  end

  always_comb begin
    went_new.row = b1_r.row;
    went_new.col = b1_r.col;
    went_new.raw = {b1_r.v2, b1_r.v3, b1_r.v4};
    went_new.g   = {g_new, gq[15:8], gq[7:0]};
  end

  // green lines: rows a-3 (top byte) and a-4 per column
  bgd_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_green (
    .clk   (clk),
    .we    (adv && b1_valid_r),
    .waddr (b1_r.col[AW-1:0]),
    .wdata ({g_new, gq[15:8]}),
    .re    (q_pop),
    .raddr (head.col[AW-1:0]),
    .rdata (gq)
  );

  // colors of the window center: left w2, center w1, right w0
  always_comb begin
    logic border, pr, pc;
    logic [1:0] nr;
    logic [7:0] vert, horz, dg, pv, gc;
    border = (w1_r.row < 13'd5) || (w1_r.row >= 13'(ctl.dims.h + 13'd1)) ||
             (w1_r.col < 13'd2) || ({1'b0, w1_r.col} + DIM_W'(2) >= ctl.dims.w);
    pr = ~w1_r.row[0];
    pc = w1_r.col[0];
    nr = (w1_r.row == 13'(ctl.dims.h + 13'd1)) ? 2'd0 : 2'd2;
    pv = w1_r.raw[1];
    gc = w1_r.g[1];
    dg = diag(w2_r.raw[0], w0_r.raw[2], w0_r.raw[0], w2_r.raw[2],
              w2_r.g[0], w0_r.g[2], w0_r.g[0], w2_r.g[2], gc);
    vert = guide(w1_r.raw[0], w1_r.raw[2], w1_r.g[0], w1_r.g[2], gc);
    horz = guide(w2_r.raw[1], w0_r.raw[1], w0_r.g[1], w2_r.g[1], gc);
    if (border) begin
      unique case ({pr, pc})
        2'b00: begin bl = w0_r.raw[nr]; gn = w0_r.raw[1]; rd = w1_r.raw[1]; end
        2'b01: begin bl = w1_r.raw[nr]; gn = w1_r.raw[1]; rd = w2_r.raw[1]; end
        2'b10: begin bl = w0_r.raw[1];  gn = w1_r.raw[1]; rd = w1_r.raw[0]; end
        2'b11: begin bl = w1_r.raw[1];  gn = w2_r.raw[1]; rd = w2_r.raw[0]; end
      endcase
    end else begin
      gn = gc;
      unique case ({pr, pc})
        2'b00: begin rd = pv;   bl = dg;   end
        2'b11: begin bl = pv;   rd = dg;   end
        2'b01: begin bl = vert; rd = horz; end
        2'b10: begin rd = vert; bl = horz; end
      endcase
    end
    emit = live_r[1] && (w1_r.row >= 13'd3) && (w1_r.row < 13'(ctl.dims.h + 13'd3));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      wv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      live_r      <= '0;
    end else begin
      if (adv) begin
        b1_valid_r  <= !q_empty;
        wv_r        <= b1_valid_r;
        out_valid_r <= wv_r && emit;
        if (b1_valid_r) live_r <= {live_r[1:0], 1'b1};
      end
      // drop any partial frame on a register write
      if (ctl.restart) live_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) b1_r <= head;
    if (adv && b1_valid_r) begin
      w2_r <= w1_r;
      w1_r <= w0_r;
      w0_r <= went_new;
    end
    if (adv) begin
      blue_r      <= bl;
      green_r     <= gn;
      red_r       <= rd;
      row_end_r   <= {1'b0, w1_r.col} + DIM_W'(1) == ctl.dims.w;
      frame_end_r <= ({1'b0, w1_r.col} + DIM_W'(1) == ctl.dims.w) &&
                     (w1_r.row == 13'(ctl.dims.h + 13'd2));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_blue      = blue_r;
  assign out_green     = green_r;
  assign out_red       = red_r;
  assign out_row_end   = row_end_r;
  assign out_frame_end = frame_end_r;

endmodule

/* tb/tb_bayer_gradient_demosaic.sv */
module tb_bayer_gradient_demosaic;
  import bgd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX    = 2048;
  localparam int HEIGHT_MAX  = 4096;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_GOAL   = 950;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       row_end;
    logic       frame_end;
  } pixel_t;

  // one directed row: a register write or a run of items with one action and pixel mode
  typedef enum logic [1:0] {ROW_ITEMS, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {PIX_FIXED, PIX_RANDOM, PIX_EXTREME} pix_mode_e;

  typedef struct {
    row_kind_e  kind;
    logic       action;
    pix_mode_e  mode;
    logic [7:0] pix;
    int         count;
    logic       typed;
    logic [7:0] blue, green, red;
    logic       reg_index;
    logic [12:0] reg_data;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [12:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [7:0]  in_raw_pixel = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_blue, out_green, out_red;
  logic        out_row_end, out_frame_end;

  bayer_gradient_demosaic dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: raw and green line stores, positions and registers.
  logic [7:0] raw_lines [5*LINE_MAX];
  logic [7:0] green_lines [3*LINE_MAX];
  int unsigned width_reg = 640, height_reg = 480;
  int unsigned in_row, in_col, out_row, out_col;

  pixel_t pending_pixels [$];
  int     mismatches = 0;
  int     accepted = 0;
  int     pixels_seen = 0;
  int     frames_seen = 0;
  int     cycles = 0;
  bit     quiet = 1'b0;
  int     gap_left = 0;
  int     stall_left = 0;

  function automatic int unsigned eff_width();
    int unsigned w = width_reg & 'hFFE;
    if (w < 4) w = 4;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h = height_reg & 'h1FFE;
    if (h < 4) h = 4;
    if (h > HEIGHT_MAX) h = HEIGHT_MAX;
    return h;
  endfunction

  function automatic int raw_at(int unsigned r, int unsigned c);
    return int'(raw_lines[(r % 5) * LINE_MAX + (c % LINE_MAX)]);
  endfunction

  function automatic int grn_at(int unsigned r, int unsigned c);
    return int'(green_lines[(r % 3) * LINE_MAX + (c % LINE_MAX)]);
  endfunction

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clip8(int v);
    return (v > 255) ? 255 : ((v < 0) ? 0 : v);
  endfunction

  function automatic bit on_edge(int unsigned r, int unsigned c, int unsigned w,
                                 int unsigned h);
    return r < 2 || r >= h - 2 || c < 2 || c >= w - 2;
  endfunction

  // green estimate at raw site (g,c): gradient-steered with Laplacian term
  function automatic int green_est(int unsigned g, int unsigned c, int unsigned w,
                                   int unsigned h);
    int p, l, rr, u, d, ll, r2, uu, dd, dh, dv;
    if (on_edge(g, c, w, h)) begin
      if (!g[0]) return c[0] ? raw_at(g, c) : raw_at(g, c + 1);
      return c[0] ? raw_at(g, c - 1) : raw_at(g, c);
    end
    p = raw_at(g, c);
    if (g[0] ^ c[0]) return p;
    l  = raw_at(g, c - 1); rr = raw_at(g, c + 1);
    u  = raw_at(g - 1, c); d  = raw_at(g + 1, c);
    ll = raw_at(g, c - 2); r2 = raw_at(g, c + 2);
    uu = raw_at(g - 2, c); dd = raw_at(g + 2, c);
    dh = mag(l - rr) + mag(2 * p - ll - r2);
    dv = mag(u - d) + mag(2 * p - uu - dd);
    if (dh < dv) return clip8((l + rr) / 2 + (2 * p - ll - r2) / 4);
    if (dh > dv) return clip8((u + d) / 2 + (2 * p - uu - dd) / 4);
    return clip8((l + rr + u + d) / 4 + (4 * p - ll - r2 - uu - dd) / 8);
  endfunction

  // opposite color at an interior R or B site along the flatter diagonal
  function automatic int diag_est(int unsigned r, int unsigned c, int gc);
    int a, b, e, f, ga, gb, ge, gf, dn, dp;
    a = raw_at(r - 1, c - 1); b = raw_at(r + 1, c + 1);
    e = raw_at(r - 1, c + 1); f = raw_at(r + 1, c - 1);
    ga = grn_at(r - 1, c - 1); gb = grn_at(r + 1, c + 1);
    ge = grn_at(r - 1, c + 1); gf = grn_at(r + 1, c - 1);
    dn = mag(a - b) + mag(2 * gc - ga - gb);
    dp = mag(e - f) + mag(2 * gc - ge - gf);
    if (dn < dp) return clip8((a + b) / 2 + (2 * gc - ga - gb) / 2);
    if (dn > dp) return clip8((e + f) / 2 + (2 * gc - ge - gf) / 2);
    return clip8((a + b + e + f) / 4 + (4 * gc - ga - gb - ge - gf) / 4);
  endfunction

  // Advance the shadow by one transaction; return 1 when a pixel leaves.
  function automatic bit demosaic_step(logic act, logic [7:0] pix, output pixel_t px);
    int unsigned w = eff_width(), h = eff_height();
    int unsigned a, b, r, c, nr;
    int bl, gn, rd, p, gc, vert, horz;
    px = '0;
    if (!act) begin
      if (in_row >= h) return 0;      // drop raw while draining
      raw_lines[(in_row % 5) * LINE_MAX + (in_col % LINE_MAX)] = pix;
    end else if (in_row < h) begin
      return 0;                        // drop flush before input is complete
    end
    a = in_row; b = in_col;
    if (a >= 2 && a - 2 < h)
      green_lines[((a - 2) % 3) * LINE_MAX + (b % LINE_MAX)] = 8'(green_est(a - 2, b, w, h));
    if (b + 1 >= w) begin
      in_col = 0; in_row = a + 1;
    end else begin
      in_col = b + 1;
    end
    if (a * w + b < 3 * w + 1) return 0;

    r = out_row; c = out_col;
    if (on_edge(r, c, w, h)) begin
      // copy from the Bayer quad; second-to-last row takes blue from above
      if (!r[0]) begin
        nr = (r == h - 2) ? r - 1 : r + 1;
        if (!c[0]) begin
          bl = raw_at(nr, c + 1); gn = raw_at(r, c + 1); rd = raw_at(r, c);
        end else begin
          bl = raw_at(nr, c); gn = raw_at(r, c); rd = raw_at(r, c - 1);
        end
      end else begin
        if (!c[0]) begin
          bl = raw_at(r, c + 1); gn = raw_at(r, c); rd = raw_at(r - 1, c);
        end else begin
          bl = raw_at(r, c); gn = raw_at(r, c - 1); rd = raw_at(r - 1, c - 1);
        end
      end
    end else begin
      p = raw_at(r, c);
      gc = grn_at(r, c);
      gn = gc;
      if (r[0] == c[0]) begin
        if (!r[0]) begin
          rd = p; bl = diag_est(r, c, gc);
        end else begin
          bl = p; rd = diag_est(r, c, gc);
        end
      end else begin
        vert = clip8((raw_at(r - 1, c) + raw_at(r + 1, c)) / 2
                     + (2 * gc - grn_at(r - 1, c) - grn_at(r + 1, c)) / 4);
        horz = clip8((raw_at(r, c - 1) + raw_at(r, c + 1)) / 2
                     + (2 * gc - grn_at(r, c + 1) - grn_at(r, c - 1)) / 4);
        if (!r[0]) begin
          bl = vert; rd = horz;
        end else begin
          rd = vert; bl = horz;
        end
      end
    end
    px.blue = 8'(bl); px.green = 8'(gn); px.red = 8'(rd);
    px.row_end = (c == w - 1);
    px.frame_end = (r == h - 1) && (c == w - 1);
    if (c + 1 >= w) begin
      out_col = 0; out_row = r + 1;
    end else begin
      out_col = c + 1;
    end
    if (px.frame_end) begin
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    end
    return 1;
  endfunction

  function automatic bit draining();
    return in_row >= eff_height();
  endfunction

  // Present one transaction and hold it until accepted; queue its pixel.
  task automatic send_item(logic act, logic [7:0] pix, logic typed = 1'b0,
                           logic [7:0] tb = '0, logic [7:0] tg = '0,
                           logic [7:0] tr = '0);
    pixel_t px;
    if (!quiet && gap_left == 0 && $urandom_range(0, 7) == 0)
      gap_left = $urandom_range(1, 16);
    while (gap_left > 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
      gap_left--;
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_raw_pixel <= pix;
    do @(posedge clk); while (in_stall);
    accepted++;
    if (demosaic_step(act, pix, px)) begin
      // constant frames: colors can be read off directly
      if (typed) begin
        px.blue = tb; px.green = tg; px.red = tr;
      end
      pending_pixels.push_back(px);
    end
  endtask

  // Hold the input idle until every queued pixel has left, plus the pipe depth.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [12:0] data);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH) width_reg = data & 'hFFF;
    else height_reg = data & 'h1FFF;
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
  endtask

  function automatic logic [7:0] pick_pixel(pix_mode_e mode, logic [7:0] fixed);
    case (mode)
      PIX_FIXED:  return fixed;
      PIX_RANDOM: return 8'($urandom_range(0, 255));
      default:    return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    endcase
  endfunction

  // One frame of random content; noise adds ignored items, an abort drops it.
  task automatic run_frame(logic [12:0] wreg, logic [12:0] hreg, pix_mode_e mode,
                           bit noise, bit abort_it, bit pause_it);
    int unsigned total, stop_at;
    write_reg(CFG_WIDTH, wreg);
    write_reg(CFG_HEIGHT, hreg);
    total = eff_width() * eff_height();
    stop_at = abort_it ? $urandom_range(1, total - 1) : total;
    for (int unsigned i = 0; i < stop_at; i++) begin
      if (noise && $urandom_range(0, 15) == 0) send_item(1'b1, 8'($urandom));
      if (pause_it && i == total / 2) wait_drained();
      send_item(1'b0, pick_pixel(mode, 8'd0));
    end
    if (abort_it) return;
    while (draining()) begin
      if (noise && $urandom_range(0, 15) == 0) send_item(1'b0, 8'($urandom));
      else send_item(1'b1, 8'($urandom));
    end
  endtask

  // Compare each pixel that leaves with the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel b=%0d g=%0d r=%0d", $time, out_blue, out_green,
                 out_red);
        mismatches++;
      end else begin
        pixel_t want;
        want = pending_pixels.pop_front();
        if (want.frame_end) frames_seen++;
        if (out_blue !== want.blue || out_green !== want.green || out_red !== want.red ||
            out_row_end !== want.row_end || out_frame_end !== want.frame_end) begin
          $display("%0t: pixel mismatch expected b=%0d g=%0d r=%0d re=%0b fe=%0b",
                   $time, want.blue, want.green, want.red, want.row_end, want.frame_end);
          $display("%0t:                actual b=%0d g=%0d r=%0d re=%0b fe=%0b",
                   $time, out_blue, out_green, out_red, out_row_end, out_frame_end);
          mismatches++;
        end
      end
    end
  end

  // Stall the result side in random bursts; none once the run goes quiet.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Bound the run; a hang ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  stim_row_t plan [] = '{
    // default 640x480 after reset: early flushes drop, a partial frame is dropped
    '{ROW_ITEMS, 1'b1, PIX_FIXED, 8'd0,   3,  1'b0, 8'd0, 8'd0, 8'd0, 1'b0, 13'd0},
    '{ROW_ITEMS, 1'b0, PIX_FIXED, 8'd17,  5,  1'b0, 8'd0, 8'd0, 8'd0, 1'b0, 13'd0},
    '{ROW_CFG,   1'b0, PIX_FIXED, 8'd0,   0,  1'b0, 8'd0, 8'd0, 8'd0, CFG_WIDTH,  13'd4},
    '{ROW_CFG,   1'b0, PIX_FIXED, 8'd0,   0,  1'b0, 8'd0, 8'd0, 8'd0, CFG_HEIGHT, 13'd4},
    '{ROW_ITEMS, 1'b1, PIX_FIXED, 8'd0,   2,  1'b0, 8'd0, 8'd0, 8'd0, 1'b0, 13'd0},
    // flat white then flat black 4x4 frames
    '{ROW_ITEMS, 1'b0, PIX_FIXED, 8'd255, 16, 1'b1, 8'd255, 8'd255, 8'd255, 1'b0, 13'd0},
    '{ROW_ITEMS, 1'b1, PIX_FIXED, 8'd0,   13, 1'b1, 8'd255, 8'd255, 8'd255, 1'b0, 13'd0},
    '{ROW_ITEMS, 1'b0, PIX_FIXED, 8'd0,   16, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0, 13'd0},
    '{ROW_ITEMS, 1'b1, PIX_FIXED, 8'd0,   13, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0, 13'd0},
    // flush after drain drops; raw during drain is discarded
    '{ROW_ITEMS, 1'b1, PIX_FIXED, 8'd0,   2,  1'b0, 8'd0, 8'd0, 8'd0, 1'b0, 13'd0},
    '{ROW_ITEMS, 1'b0, PIX_EXTREME, 8'd0, 16, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, 13'd0},
    '{ROW_ITEMS, 1'b0, PIX_RANDOM, 8'd0,  3,  1'b0, 8'd0, 8'd0, 8'd0, 1'b0, 13'd0},
    '{ROW_ITEMS, 1'b1, PIX_FIXED, 8'd0,   13, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, 13'd0},
    // 6x6 random frame to reach interior pixels
    '{ROW_CFG,   1'b0, PIX_FIXED, 8'd0,   0,  1'b0, 8'd0, 8'd0, 8'd0, CFG_WIDTH,  13'd7},
    '{ROW_CFG,   1'b0, PIX_FIXED, 8'd0,   0,  1'b0, 8'd0, 8'd0, 8'd0, CFG_HEIGHT, 13'd6},
    '{ROW_ITEMS, 1'b0, PIX_RANDOM, 8'd0,  36, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, 13'd0},
    '{ROW_ITEMS, 1'b1, PIX_FIXED, 8'd0,   19, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, 13'd0}
  };

  initial begin
    int unsigned wsel, hsel;
    // hold reset low at start, then release at a rising edge
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].reg_index, plan[i].reg_data);
      end else begin
        for (int k = 0; k < plan[i].count; k++)
          send_item(plan[i].action, pick_pixel(plan[i].mode, plan[i].pix), plan[i].typed,
                    plan[i].blue, plan[i].green, plan[i].red);
      end
    end

    // register extremes: widest row, tallest frame, and values below the floor
    run_frame(13'h1FFF, 13'd4, PIX_RANDOM, 1'b0, 1'b0, 1'b0);
    run_frame(13'd1, 13'h1FFF, PIX_EXTREME, 1'b0, 1'b0, 1'b0);
    run_frame(13'd0, 13'd3, PIX_RANDOM, 1'b1, 1'b0, 1'b1);
    accepted = 0;

    // random frames, mostly small; a few broken ones are cut short by a write
    while (accepted < ITEM_GOAL) begin
      if (accepted > ITEM_GOAL * 4 / 5) quiet = 1'b1;
      wsel = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(4, 14);
      hsel = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(4, 8);
      run_frame(13'(wsel), 13'(hsel),
                ($urandom_range(0, 4) == 0) ? PIX_EXTREME : PIX_RANDOM,
                $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0,
                $urandom_range(0, 7) == 0);
    end

    wait_drained();
    $display("Covered directed flat and random frames, register extremes, dropped");
    $display("flushes and raws, aborted frames; %0d pixels over %0d frames checked.",
             pixels_seen, frames_seen);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
